>>> design/gcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_pkg
// shared types for the gcd unit: controller states and the command and
// status groups that join the controller to the datapath
// ----------------------------------------------------------------------------
package gcd_pkg;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } gcd_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;     // take a new pair of operands
    logic step;     // one subtract/shift iteration
    logic capture;  // move the finished result into the output register
  } gcd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;     // one operand has reached zero
  } gcd_status_t;

endpackage

>>> design/gcd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_dp
// datapath: operand registers, shared subtract/shift unit, common power of
// two counter and the output register
// ----------------------------------------------------------------------------
module gcd_dp #(
  parameter int WIDTH = 32
) (
  input  logic                 clk_i,
  input  gcd_pkg::gcd_cmd_t    cmd_i,
  output gcd_pkg::gcd_status_t status_o,
  input  logic [WIDTH-1:0]     a_value_i,
  input  logic [WIDTH-1:0]     b_value_i,
  output logic [WIDTH-1:0]     divisor_o
);
  import gcd_pkg::*;

  localparam int KW = $clog2(WIDTH);

  logic [WIDTH-1:0] a_q, a_d;
  logic [WIDTH-1:0] b_q, b_d;
  logic [KW-1:0]    k_q, k_d;
  logic [WIDTH-1:0] res_q;
  logic [WIDTH-1:0] diff_ab;
  logic [WIDTH-1:0] diff_ba;
  logic             a_ge_b;

  // subtractors for both directions
  assign diff_ab = a_q - b_q;
  assign diff_ba = b_q - a_q;
  assign a_ge_b  = (a_q >= b_q);

  // one binary gcd iteration or a fresh load
  always_comb begin
    a_d = a_q;
    b_d = b_q;
    k_d = k_q;
    if (cmd_i.load) begin
      a_d = a_value_i;
      b_d = b_value_i;
      k_d = '0;
    end else if (cmd_i.step) begin
      if (!a_q[0] && !b_q[0]) begin
        // common factor of two
        a_d = a_q >> 1;
        b_d = b_q >> 1;
        k_d = k_q + 1'b1;
      end else if (!a_q[0]) begin
        a_d = a_q >> 1;
      end else if (!b_q[0]) begin
        b_d = b_q >> 1;
      end else if (a_ge_b) begin
        // difference of two odd values is even
        a_d = diff_ab >> 1;
      end else begin
        b_d = diff_ba >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    k_q <= k_d;
  end

  // output register, restores the common power of two
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      res_q <= (a_q | b_q) << k_q;
    end
  end

  assign status_o.done = (a_q == '0) || (b_q == '0);
  assign divisor_o     = res_q;

endmodule

>>> design/gcd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_ctrl
// controller: sequences load, iterations and result capture, and owns the
// handshakes of both channels
// ----------------------------------------------------------------------------
module gcd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output gcd_pkg::gcd_cmd_t    cmd_o,
  input  gcd_pkg::gcd_status_t status_i
);
  import gcd_pkg::*;

  gcd_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       in_take;

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_take  = in_valid_i && (state_q == ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (status_i.done && out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_RUN: begin
        cmd_o.step    = !status_i.done;
        cmd_o.capture = status_i.done && out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // output item valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.capture) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  // capture only once iterations have finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |-> (state_q == ST_RUN) && status_i.done)
    else $error("capture without finished result");

  // a captured result is presented next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> out_valid_o)
    else $error("captured result not presented");

  // an accepted item starts iterating
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> (state_q == ST_RUN))
    else $error("accepted item not running");

  // never overwrite a result still waiting downstream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |-> !(out_valid_q && out_stall_i))
    else $error("pending result overwritten");
`endif

endmodule

>>> design/gcd_euclid_32_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_euclid_32_unit
// greatest common divisor of two unsigned operands
// ----------------------------------------------------------------------------
// usage
//   input channel: a_value_i and b_value_i with in_valid_i; an item is taken
//   at a clock edge with in_valid_i high and in_stall_o low.
//   output channel: divisor_o with out_valid_o; taken at an edge with
//   out_valid_o high and out_stall_i low. one result per input item.
//   gcd(0, b) = b, gcd(a, 0) = a, gcd(0, 0) = 0.
// timing
//   one item is worked at a time: the load, then the binary gcd
//   iterations of the shared subtract/shift unit until one operand is
//   zero, then the capture into the output register.
//   the iteration count depends on the operand values.
//   a new item is taken the cycle after capture, while the previous result
//   may still wait in the output register.
// reset and stall
//   reset clears the controller and drops out_valid_o; operands are not
//   cleared. while out_stall_i is high the result holds, and a finished
//   item waits in the unit until the output register frees up.
// ----------------------------------------------------------------------------
module gcd_euclid_32_unit #(
  parameter int WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [WIDTH-1:0] a_value_i,
  input  logic [WIDTH-1:0] b_value_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [WIDTH-1:0] divisor_o
);
  import gcd_pkg::*;

  gcd_cmd_t    cmd;
  gcd_status_t status;

  // control sequencing and handshakes
  gcd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // operand registers and iteration unit
  gcd_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .status_o  (status),
    .a_value_i (a_value_i),
    .b_value_i (b_value_i),
    .divisor_o (divisor_o)
  );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the gcd unit: a table of edge-case operand pairs,
// then shaped random pairs (full random, shared factors, fibonacci worst
// cases, zeros, equal, small, shifted, multiples), each result checked in
// order against table or euclid loop, with random idling on both channels
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WIDTH      = 32;
  localparam int RAND_ITEMS = 1330;
  localparam int WDOG_LIMIT = 4000;
  localparam int IDLE_PCT   = 31;
  localparam int CALM_LO    = 500;
  localparam int CALM_HI    = 800;

  typedef logic [WIDTH-1:0] word_t;

  // one operand pair, with the result typed in where it is obvious
  typedef struct packed {
    word_t a;
    word_t b;
    word_t gold;
    bit    known;
  } gcd_row_t;

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  in_valid_i  = 1'b0;
  logic  out_stall_i = 1'b0;
  word_t a_value_i   = '0;
  word_t b_value_i   = '0;
  logic  in_stall_o;
  logic  out_valid_o;
  word_t divisor_o;

  gcd_row_t pair_q[$];     // operand pairs not yet offered
  gcd_row_t gcd_q[$];      // accepted pairs waiting for their divisor
  gcd_row_t cur_pair;
  int       sent_cnt     = 0;
  int       result_cnt   = 0;
  int       mismatch_cnt = 0;
  int       quiet_cycles = 0;

  // edge cases, most with the divisor read off directly
  localparam int DIR_ROWS = 18;
  localparam gcd_row_t DIR_TAB [DIR_ROWS] = '{
    '{a: 32'h0000_0000, b: 32'h0000_0000, gold: 32'h0000_0000, known: 1'b1},
    '{a: 32'h0000_0000, b: 32'hFFFF_FFFF, gold: 32'hFFFF_FFFF, known: 1'b1},
    '{a: 32'hFFFF_FFFF, b: 32'h0000_0000, gold: 32'hFFFF_FFFF, known: 1'b1},
    '{a: 32'hFFFF_FFFF, b: 32'hFFFF_FFFF, gold: 32'hFFFF_FFFF, known: 1'b1},
    '{a: 32'h0000_0000, b: 32'h0000_0005, gold: 32'h0000_0005, known: 1'b1},
    '{a: 32'h0000_0005, b: 32'h0000_0000, gold: 32'h0000_0005, known: 1'b1},
    '{a: 32'h0000_0001, b: 32'hFFFF_FFFF, gold: 32'h0000_0001, known: 1'b1},
    '{a: 32'hFFFF_FFFF, b: 32'h0000_0001, gold: 32'h0000_0001, known: 1'b1},
    '{a: 32'h0000_0001, b: 32'h0000_0001, gold: 32'h0000_0001, known: 1'b1},
    '{a: 32'h0000_000C, b: 32'h0000_0012, gold: 32'h0000_0006, known: 1'b1},
    '{a: 32'h0000_0012, b: 32'h0000_000C, gold: 32'h0000_0006, known: 1'b1},
    '{a: 32'h8000_0000, b: 32'h4000_0000, gold: 32'h4000_0000, known: 1'b1},
    '{a: 32'h8000_0000, b: 32'h8000_0000, gold: 32'h8000_0000, known: 1'b1},
    '{a: 32'hFFFF_FFFE, b: 32'hFFFF_FFFF, gold: 32'h0000_0001, known: 1'b1},
    '{a: 32'd1836311903, b: 32'd2971215073, gold: 32'h0000_0001, known: 1'b1},
    '{a: 32'd2971215073, b: 32'd1836311903, gold: 32'h0000_0001, known: 1'b1},
    '{a: 32'd123456789, b: 32'd987654321, gold: 32'h0000_0000, known: 1'b0},
    '{a: 32'hAAAA_AAAA, b: 32'h5555_5555, gold: 32'h0000_0000, known: 1'b0}
  };

  // euclid remainder loop
  function automatic word_t euclid_gcd(input word_t x, input word_t y);
    word_t rem;
    while (x != '0) begin
      rem = y % x;
      y   = x;
      x   = rem;
    end
    return y;
  endfunction

  // one random operand pair, shaped toward interesting divisors
  function automatic gcd_row_t random_pair();
    gcd_row_t row;
    word_t    g, lim, f0, f1, t;
    int       k;
    row = '0;
    case ($urandom_range(9))
      0, 1, 2: begin
        row.a = $urandom;
        row.b = $urandom;
      end
      3: begin
        // shared factor
        g     = $urandom_range(65535, 1);
        lim   = 32'hFFFF_FFFF / g;
        row.a = g * word_t'($urandom_range(lim, 0));
        row.b = g * word_t'($urandom_range(lim, 0));
      end
      4: begin
        // consecutive fibonacci numbers, the longest loops
        f0 = 0;
        f1 = 1;
        k  = $urandom_range(46, 1);
        repeat (k) begin
          t  = f0 + f1;
          f0 = f1;
          f1 = t;
        end
        if ($urandom_range(1)) begin
          row.a = f0;
          row.b = f1;
        end else begin
          row.a = f1;
          row.b = f0;
        end
      end
      5: begin
        // one operand zero
        if ($urandom_range(1)) begin
          row.a = '0;
          row.b = $urandom;
        end else begin
          row.a = $urandom;
          row.b = '0;
        end
      end
      6: begin
        row.a = $urandom;
        row.b = row.a;
      end
      7: begin
        row.a = $urandom_range(255);
        row.b = $urandom_range(255);
      end
      8: begin
        row.a = word_t'($urandom) << $urandom_range(31);
        row.b = word_t'($urandom) << $urandom_range(31);
      end
      default: begin
        // one operand a multiple of the other
        row.a = $urandom_range(65535, 1);
        row.b = row.a * word_t'($urandom_range(65535));
        if ($urandom_range(1)) begin
          t     = row.a;
          row.a = row.b;
          row.b = t;
        end
      end
    endcase
    return row;
  endfunction

  task automatic report_mismatch(input string what, input gcd_row_t row, input word_t got);
    mismatch_cnt++;
    $display("%0t: %s: a=%h b=%h expected %h got %h",
             $time, what, row.a, row.b, row.gold, got);
  endtask

  // clock
  always #4 clk_i = ~clk_i;

  gcd_euclid_32_unit #(
    .WIDTH(WIDTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .a_value_i  (a_value_i),
    .b_value_i  (b_value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .divisor_o  (divisor_o)
  );

  // input side: record accepted items, offer the next one
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (!cur_pair.known)
          cur_pair.gold = euclid_gcd(cur_pair.a, cur_pair.b);
        gcd_q.push_back(cur_pair);
        sent_cnt++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pair_q.size() > 0 &&
            ((sent_cnt >= CALM_LO && sent_cnt < CALM_HI) ||
             $urandom_range(99) >= IDLE_PCT)) begin
          cur_pair   = pair_q.pop_front();
          in_valid_i <= 1'b1;
          a_value_i  <= cur_pair.a;
          b_value_i  <= cur_pair.b;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output side: check each result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (gcd_q.size() == 0)
          report_mismatch("unexpected result", '0, divisor_o);
        else if (divisor_o !== gcd_q[0].gold)
          report_mismatch("wrong divisor", gcd_q.pop_front(), divisor_o);
        else
          void'(gcd_q.pop_front());
        result_cnt++;
      end
      out_stall_i <= !(result_cnt >= CALM_LO && result_cnt < CALM_HI) &&
                     ($urandom_range(99) < IDLE_PCT);
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // stimulus build, reset and end of run
  initial begin
    for (int i = 0; i < DIR_ROWS; i++)
      pair_q.push_back(DIR_TAB[i]);
    repeat (RAND_ITEMS)
      pair_q.push_back(random_pair());
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i);
    while (pair_q.size() > 0 || in_valid_i || gcd_q.size() > 0);
    repeat (150) @(posedge clk_i);
    if (mismatch_cnt == 0 && gcd_q.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
